### hdl/udsbd_pkg.sv
`timescale 1ns / 1ps
package udsbd_pkg;
	localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;
	localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [1:0] CfgMaxBlob = 2'd0;
	localparam logic [1:0] CfgTimeout = 2'd1;
	localparam logic [1:0] CfgBlockLen = 2'd2;
	localparam logic [7:0] SidDownload = 8'h34;
	localparam logic [7:0] SidTransfer = 8'h36;
	localparam logic [7:0] SidExit = 8'h37;
	localparam logic [7:0] SidTester = 8'h3E;
	localparam logic [7:0] SidRoutine = 8'h31;
	localparam logic [7:0] RspNegative = 8'h7F;
	localparam logic [7:0] RspDownload = 8'h74;
	localparam logic [7:0] RspLengthFormat = 8'h20;
	localparam logic [7:0] RspTransfer = 8'h76;
	localparam logic [7:0] RspExit = 8'h77;
	localparam logic [7:0] RspTester = 8'h7E;
	localparam logic [7:0] NrcNotSupported = 8'h11;
	localparam logic [7:0] NrcSubFunction = 8'h12;
	localparam logic [7:0] NrcLength = 8'h13;
	localparam logic [7:0] NrcSequence = 8'h24;
	localparam logic [7:0] NrcOutOfRange = 8'h31;
	localparam logic [7:0] NrcRejected = 8'h70;
	localparam logic [7:0] NrcSuspended = 8'h71;
	localparam logic [7:0] NrcProgFail = 8'h72;
	localparam logic [7:0] NrcBadCounter = 8'h73;
	localparam logic [1:0] StatNone = 2'd0;
	localparam logic [1:0] StatCrcOk = 2'd1;
	localparam logic [1:0] StatUnchecked = 2'd2;
	localparam logic [1:0] StatCrcFail = 2'd3;

	typedef struct packed {
		logic [7:0] resp_byte;
		logic resp_last;
		logic [1:0] blob_status;
		logic [31:0] blob_address;
		logic [31:0] blob_length;
	} out_item_t;

	typedef struct packed {
		logic req_type;
		logic [7:0] data_byte;
		logic msg_last;
	} in_item_t;

	// one response: up to four bytes, shared status fields
	typedef struct packed {
		logic [2:0] count;
		logic [3:0][7:0] bytes;
		logic [1:0] blob_status;
		logic [31:0] blob_address;
		logic [31:0] blob_length;
	} resp_t;

	function automatic logic [31:0] crc_entry(input logic [7:0] idx);
		logic [31:0] c;
		c = {24'd0, idx};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		return c;
	endfunction
endpackage

### hdl/udsbd_if.sv
`timescale 1ns / 1ps
interface udsbd_in_if;
	logic valid;
	logic ready;
	udsbd_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface udsbd_out_if;
	logic valid;
	logic ready;
	udsbd_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/udsbd_serializer.sv
`timescale 1ns / 1ps
module udsbd_serializer (
	input logic clk,
	input logic arst_n,
	input logic load,
	input udsbd_pkg::resp_t resp,
	output logic can_load,
	udsbd_out_if.source out_ch
);
	import udsbd_pkg::*;

	resp_t buf_q;
	logic [2:0] pos_q;
	logic busy_q;
	logic take;
	logic done;

	assign take = busy_q && out_ch.ready;
	assign done = take && (pos_q + 3'd1 == buf_q.count);
	assign can_load = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
		end else if (load && can_load) begin
			busy_q <= (resp.count != 3'd0);
			pos_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (take) begin
			pos_q <= pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load)
			buf_q <= resp;
	end

	assign out_ch.valid = busy_q;
	assign out_ch.data.resp_byte = buf_q.bytes[pos_q[1:0]];
	assign out_ch.data.resp_last = (pos_q + 3'd1 == buf_q.count);
	assign out_ch.data.blob_status = buf_q.blob_status;
	assign out_ch.data.blob_address = buf_q.blob_address;
	assign out_ch.data.blob_length = buf_q.blob_length;
endmodule

### hdl/uds_block_download_receiver.sv
`timescale 1ns / 1ps
// UDS block-download receiver. Each transaction on in_ch is one request byte or
// one timeout tick; each answer byte leaves on out_ch as one transaction. An
// item is processed from an input register into a response register; the input
// side stays ready while the response register holds a previous answer, and stalls
// only on the closing byte of a message while an earlier answer of up to four bytes
// is still draining (one byte per cycle while out_ch is ready).
// The CRC-32 uses a 256-entry constant table, one lookup per data byte.
module uds_block_download_receiver (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	udsbd_in_if.sink in_ch,
	udsbd_out_if.source out_ch
);
	import udsbd_pkg::*;

	logic [31:0] max_blob_q;
	logic [15:0] timeout_q, blk_len_q;
	logic active_q;
	logic [31:0] load_addr_q, exp_size_q, rcv_cnt_q;
	logic [7:0] exp_seq_q;
	logic [31:0] crc_q, tail_q, sv_crc_q, sv_tail_q;
	logic [2:0] fill_q, sv_fill_q;
	logic [7:0] sid_q, fmt_q, sec_q;
	logic [15:0] idx_q, idle_q;
	logic [31:0] addr_acc_q, size_acc_q;

	logic v_s1;
	in_item_t it_s1;
	logic ld;
	resp_t resp;
	logic can_load;

	// input register: hold when a closing byte cannot hand off its answer
	logic stall;
	assign stall = v_s1 && !it_s1.req_type && it_s1.msg_last && !can_load;
	assign in_ch.ready = !stall;
	assign ld = v_s1 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (!stall)
			v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (!stall && in_ch.valid)
			it_s1 <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_blob_q <= 32'd16777216;
			timeout_q <= 16'd30;
			blk_len_q <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgMaxBlob: max_blob_q <= cfg_data;
				CfgTimeout: timeout_q <= cfg_data[15:0];
				CfgBlockLen: blk_len_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [7:0] b;
	logic [3:0] al, sl;
	logic fmt_ok;
	logic [31:0] crc_f, tail_f;
	logic [2:0] fill_f;
	logic [15:0] idle_inc;
	logic [16:0] len;
	logic [16:0] need;
	logic [32:0] sum;
	logic [15:0] payload_cnt;

	always_comb begin
		b = it_s1.data_byte;
		al = fmt_q[3:0];
		sl = fmt_q[7:4];
		fmt_ok = al >= 4'd1 && al <= 4'd4 && sl >= 4'd1 && sl <= 4'd4;
		crc_f = crc_q;
		tail_f = tail_q;
		fill_f = fill_q;
		if (fill_q < 3'd4) begin
			tail_f = tail_q | ({24'd0, b} << {fill_q[1:0], 3'b000});
			fill_f = fill_q + 3'd1;
		end else begin
			crc_f = (crc_q >> 8) ^ crc_entry(crc_q[7:0] ^ tail_q[7:0]);
			tail_f = {b, tail_q[31:8]};
		end
		idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
		len = {1'b0, idx_q} + 17'd1;
		need = 17'd3 + {13'd0, al} + {13'd0, sl};
		payload_cnt = idx_q - 16'd1;
		sum = {1'b0, rcv_cnt_q} + {17'd0, payload_cnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0; load_addr_q <= '0; exp_size_q <= '0; rcv_cnt_q <= '0;
			exp_seq_q <= 8'd1; crc_q <= CrcOnes; tail_q <= '0; fill_q <= '0;
			sv_crc_q <= CrcOnes; sv_tail_q <= '0; sv_fill_q <= '0;
			sid_q <= '0; idx_q <= '0; fmt_q <= '0; sec_q <= '0;
			addr_acc_q <= '0; size_acc_q <= '0; idle_q <= '0;
		end else if (ld) begin
			if (it_s1.req_type) begin
				if (active_q) begin
					if (idle_inc > timeout_q) begin
						active_q <= 1'b0; rcv_cnt_q <= '0; exp_seq_q <= 8'd1;
						exp_size_q <= '0; crc_q <= CrcOnes; tail_q <= '0; fill_q <= '0;
						sv_crc_q <= CrcOnes; sv_tail_q <= '0; sv_fill_q <= '0;
						idle_q <= '0;
					end else begin
						idle_q <= idle_inc;
					end
				end
			end else begin
				logic [7:0] sid_n, sec_n, fmt_n, seq_n;
				logic [31:0] sz_n, ad_n, crc_n, tail_n, svc_n, svt_n;
				logic [31:0] rcv_n, exp_n, load_n;
				logic [2:0] fill_n, svf_n;
				logic [15:0] idle_n;
				logic act_n;
				sid_n = sid_q; sec_n = sec_q; fmt_n = fmt_q;
				sz_n = size_acc_q; ad_n = addr_acc_q;
				crc_n = crc_q; tail_n = tail_q; fill_n = fill_q;
				svc_n = sv_crc_q; svt_n = sv_tail_q; svf_n = sv_fill_q;
				act_n = active_q; rcv_n = rcv_cnt_q; seq_n = exp_seq_q;
				exp_n = exp_size_q; load_n = load_addr_q; idle_n = idle_q;
				if (idx_q == 16'd0) begin
					sid_n = b; sec_n = '0; fmt_n = '0; ad_n = '0; sz_n = '0;
					svc_n = crc_q; svt_n = tail_q; svf_n = fill_q;
				end else if (idx_q == 16'd1) begin
					sec_n = b;
				end else if (idx_q == 16'd2) begin
					fmt_n = b;
				end else if (sid_q == SidDownload && fmt_ok) begin
					if ({1'b0, idx_q} < 17'd3 + {13'd0, al})
						ad_n = {addr_acc_q[23:0], b};
					else if ({1'b0, idx_q} < need)
						sz_n = {size_acc_q[23:0], b};
				end
				if (idx_q >= 16'd2 && sid_q == SidTransfer && active_q) begin
					crc_n = crc_f; tail_n = tail_f; fill_n = fill_f;
				end
				if (it_s1.msg_last) begin
					if (sid_n == SidDownload) begin
						if (!active_q && len >= 17'd4 && fmt_ok && len >= need
								&& sz_n != 32'd0 && sz_n <= max_blob_q) begin
							act_n = 1'b1; rcv_n = '0; seq_n = 8'd1;
							crc_n = CrcOnes; tail_n = '0; fill_n = '0;
							svc_n = CrcOnes; svt_n = '0; svf_n = '0;
							idle_n = '0;
							load_n = ad_n; exp_n = sz_n;
						end
					end else if (sid_n == SidTransfer) begin
						if (!active_q || len < 17'd2 || sec_n != exp_seq_q
								|| idx_q == 16'hFFFF || sum > {1'b0, exp_size_q}) begin
							crc_n = svc_n; tail_n = svt_n; fill_n = svf_n;
						end else begin
							rcv_n = sum[31:0];
							seq_n = exp_seq_q + 8'd1;
							idle_n = '0;
						end
					end else if (sid_n == SidExit && active_q) begin
						act_n = 1'b0; rcv_n = '0; seq_n = 8'd1;
						exp_n = '0; crc_n = CrcOnes; tail_n = '0; fill_n = '0;
						svc_n = CrcOnes; svt_n = '0; svf_n = '0;
						idle_n = '0;
					end
				end
				sid_q <= sid_n; sec_q <= sec_n; fmt_q <= fmt_n;
				addr_acc_q <= ad_n; size_acc_q <= sz_n;
				crc_q <= crc_n; tail_q <= tail_n; fill_q <= fill_n;
				sv_crc_q <= svc_n; sv_tail_q <= svt_n; sv_fill_q <= svf_n;
				active_q <= act_n; rcv_cnt_q <= rcv_n; exp_seq_q <= seq_n;
				exp_size_q <= exp_n; load_addr_q <= load_n; idle_q <= idle_n;
				if (!it_s1.msg_last) begin
					if (idx_q != 16'hFFFF)
						idx_q <= idx_q + 16'd1;
				end else begin
					idx_q <= '0;
				end
			end
		end
	end

	// answer for a closing byte; sid/second are taken from the state only when the
	// message is longer than the field position, the format always from the state
	logic [7:0] sid_c, sec_c;
	always_comb begin
		sid_c = (idx_q == 16'd0) ? b : sid_q;
		sec_c = (idx_q == 16'd1) ? b : ((idx_q == 16'd0) ? 8'd0 : sec_q);
		resp = '0;
		resp.bytes[0] = RspNegative;
		resp.bytes[1] = sid_c;
		resp.count = 3'd3;
		unique case (sid_c)
			SidDownload: begin
				// fields are complete only with len >= 4, which implies idx >= 3
				if (active_q) resp.bytes[2] = NrcRejected;
				else if (len < 17'd4) resp.bytes[2] = NrcLength;
				else if (!fmt_ok) resp.bytes[2] = NrcOutOfRange;
				else if (len < need) resp.bytes[2] = NrcLength;
				else if (size_acc_q == 32'd0 && !({1'b0, idx_q} < need
						&& {1'b0, idx_q} >= 17'd3 + {13'd0, al}))
					resp.bytes[2] = NrcRejected;
				else begin
					logic [31:0] sz;
					sz = ({1'b0, idx_q} < need && {1'b0, idx_q} >= 17'd3 + {13'd0, al})
						? {size_acc_q[23:0], b} : size_acc_q;
					if (sz == 32'd0 || sz > max_blob_q) resp.bytes[2] = NrcRejected;
					else begin
						resp.count = 3'd4;
						resp.bytes[0] = RspDownload; resp.bytes[1] = RspLengthFormat;
						resp.bytes[2] = blk_len_q[15:8]; resp.bytes[3] = blk_len_q[7:0];
					end
				end
			end
			SidTransfer: begin
				if (!active_q) resp.bytes[2] = NrcSequence;
				else if (len < 17'd2) resp.bytes[2] = NrcLength;
				else if (sec_c != exp_seq_q) resp.bytes[2] = NrcBadCounter;
				else if (idx_q == 16'hFFFF || sum > {1'b0, exp_size_q})
					resp.bytes[2] = NrcSuspended;
				else begin
					resp.count = 3'd2;
					resp.bytes[0] = RspTransfer; resp.bytes[1] = sec_c;
				end
			end
			SidExit: begin
				if (!active_q) resp.bytes[2] = NrcSequence;
				else begin
					resp.blob_address = load_addr_q;
					if (fill_q >= 3'd4) begin
						resp.blob_length = rcv_cnt_q - 32'd4;
						if ((crc_q ^ CrcOnes) == tail_q) begin
							resp.count = 3'd1; resp.bytes[0] = RspExit;
							resp.blob_status = StatCrcOk;
						end else begin
							resp.bytes[2] = NrcProgFail;
							resp.blob_status = StatCrcFail;
						end
					end else begin
						resp.count = 3'd1; resp.bytes[0] = RspExit;
						resp.blob_status = StatUnchecked;
						resp.blob_length = rcv_cnt_q;
					end
				end
			end
			SidTester: begin
				if (len >= 17'd2 && sec_c[7]) resp.count = 3'd0;
				else begin
					resp.count = 3'd2; resp.bytes[0] = RspTester; resp.bytes[1] = 8'h00;
				end
			end
			SidRoutine: resp.bytes[2] = NrcSubFunction;
			default: resp.bytes[2] = NrcNotSupported;
		endcase
	end

	udsbd_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.load(ld && !it_s1.req_type && it_s1.msg_last),
		.resp(resp),
		.can_load(can_load),
		.out_ch(out_ch)
	);
endmodule

### hdl/udsbd_checker.sv
`timescale 1ns / 1ps
module udsbd_sva (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] blob_status,
	input logic [31:0] blob_address,
	input logic [31:0] blob_length,
	input logic [7:0] resp_byte
);
	import udsbd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blob_status == StatNone
		|-> blob_address == 32'd0 && blob_length == 32'd0)
		else $error("blob fields without status");
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (blob_status == StatCrcOk || blob_status == StatUnchecked)
		|-> resp_byte == RspExit)
		else $error("bad exit answer");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid) else $error("stall without pending result");
endmodule

bind uds_block_download_receiver udsbd_sva u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.blob_status(out_ch.data.blob_status), .blob_address(out_ch.data.blob_address),
	.blob_length(out_ch.data.blob_length), .resp_byte(out_ch.data.resp_byte)
);

### sim/udsbd_checker.sv
`timescale 1ns / 1ps
module udsbd_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input udsbd_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input udsbd_pkg::out_item_t out_data,
	output int fail_count,
	output int pending_count
);
	import udsbd_pkg::*;

	logic [31:0] max_blob;
	logic [15:0] timeout_lim;
	logic [15:0] block_len;

	logic active;
	logic [31:0] load_addr, exp_size, rcv_count;
	logic [7:0] exp_seq;
	logic [31:0] crc, tail, sv_crc, sv_tail;
	logic [2:0] fill, sv_fill;
	logic [7:0] sid, seq_byte, fmt;
	logic [15:0] msg_idx;
	logic [31:0] addr_acc, size_acc;
	logic [15:0] idle_cnt;
	logic [31:0] crc_lut [256];

	out_item_t expected_resp [$];

	assign pending_count = expected_resp.size();

	function automatic logic [31:0] lut_entry(input logic [7:0] i);
		logic [31:0] c;
		c = {24'd0, i};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		return c;
	endfunction

	task automatic clear_transfer();
		active = 1'b0;
		rcv_count = '0;
		exp_seq = 8'd1;
		exp_size = '0;
		crc = CrcOnes;
		tail = '0;
		fill = '0;
		sv_crc = CrcOnes;
		sv_tail = '0;
		sv_fill = '0;
		idle_cnt = '0;
	endtask

	task automatic push_resp(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input int n,
			input logic [1:0] st, input logic [31:0] ad, input logic [31:0] ln);
		logic [7:0] bs [4];
		out_item_t r;
		bs[0] = b0; bs[1] = b1; bs[2] = b2; bs[3] = b3;
		for (int k = 0; k < n; k++) begin
			r.resp_byte = bs[k];
			r.resp_last = (k == n - 1);
			r.blob_status = st;
			r.blob_address = ad;
			r.blob_length = ln;
			expected_resp.push_back(r);
		end
	endtask

	task automatic reject(input logic [7:0] s, input logic [7:0] nrc);
		push_resp(RspNegative, s, nrc, 8'd0, 3, StatNone, 32'd0, 32'd0);
	endtask

	task automatic predict_item(input in_item_t it);
		logic [7:0] b;
		logic [15:0] idx;
		logic [31:0] len, al, sl, dlen;
		b = it.data_byte;
		idx = msg_idx;
		if (it.req_type) begin
			if (active) begin
				if (idle_cnt != 16'hFFFF) idle_cnt++;
				if (idle_cnt > timeout_lim) clear_transfer();
			end
			return;
		end
		al = {28'd0, fmt[3:0]};
		sl = {28'd0, fmt[7:4]};
		if (idx == 16'd0) begin
			sid = b; seq_byte = '0; fmt = '0; addr_acc = '0; size_acc = '0;
			sv_crc = crc; sv_tail = tail; sv_fill = fill;
		end else if (idx == 16'd1) begin
			seq_byte = b;
		end else if (idx == 16'd2) begin
			fmt = b;
		end else if (sid == SidDownload && al >= 1 && al <= 4 && sl >= 1 && sl <= 4) begin
			if (idx < 3 + al) addr_acc = {addr_acc[23:0], b};
			else if (idx < 3 + al + sl) size_acc = {size_acc[23:0], b};
		end
		if (idx >= 16'd2 && sid == SidTransfer && active) begin
			if (fill < 3'd4) begin
				tail = tail | ({24'd0, b} << (8 * fill));
				fill++;
			end else begin
				crc = (crc >> 8) ^ crc_lut[crc[7:0] ^ tail[7:0]];
				tail = {b, tail[31:8]};
			end
		end
		if (!it.msg_last) begin
			if (msg_idx != 16'hFFFF) msg_idx++;
			return;
		end
		msg_idx = '0;
		len = {16'd0, idx} + 32'd1;
		al = {28'd0, fmt[3:0]};
		sl = {28'd0, fmt[7:4]};
		case (sid)
			SidDownload: begin
				if (active) reject(SidDownload, NrcRejected);
				else if (len < 4) reject(SidDownload, NrcLength);
				else if (al == 0 || al > 4 || sl == 0 || sl > 4)
					reject(SidDownload, NrcOutOfRange);
				else if (len < 3 + al + sl) reject(SidDownload, NrcLength);
				else if (size_acc == 0 || size_acc > max_blob)
					reject(SidDownload, NrcRejected);
				else begin
					clear_transfer();
					active = 1'b1;
					load_addr = addr_acc;
					exp_size = size_acc;
					push_resp(RspDownload, RspLengthFormat, block_len[15:8], block_len[7:0], 4,
						StatNone, 32'd0, 32'd0);
				end
			end
			SidTransfer: begin
				if (!active) begin
					crc = sv_crc; tail = sv_tail; fill = sv_fill;
					reject(SidTransfer, NrcSequence);
				end else if (len < 2) begin
					crc = sv_crc; tail = sv_tail; fill = sv_fill;
					reject(SidTransfer, NrcLength);
				end else if (seq_byte != exp_seq) begin
					crc = sv_crc; tail = sv_tail; fill = sv_fill;
					reject(SidTransfer, NrcBadCounter);
				end else if (idx == 16'hFFFF ||
						{32'd0, rcv_count} + {32'd0, len - 32'd2} > {32'd0, exp_size}) begin
					crc = sv_crc; tail = sv_tail; fill = sv_fill;
					reject(SidTransfer, NrcSuspended);
				end else begin
					rcv_count += len - 32'd2;
					exp_seq++;
					idle_cnt = '0;
					push_resp(RspTransfer, seq_byte, 8'd0, 8'd0, 2, StatNone, 32'd0, 32'd0);
				end
			end
			SidExit: begin
				if (!active) reject(SidExit, NrcSequence);
				else begin
					if (fill >= 3'd4) begin
						dlen = rcv_count - 32'd4;
						if ((crc ^ CrcOnes) == tail)
							push_resp(RspExit, 8'd0, 8'd0, 8'd0, 1, StatCrcOk, load_addr, dlen);
						else
							push_resp(RspNegative, SidExit, NrcProgFail, 8'd0, 3,
								StatCrcFail, load_addr, dlen);
					end else
						push_resp(RspExit, 8'd0, 8'd0, 8'd0, 1, StatUnchecked, load_addr,
							rcv_count);
					clear_transfer();
				end
			end
			SidTester: begin
				if (!(len >= 2 && seq_byte[7]))
					push_resp(RspTester, 8'h00, 8'd0, 8'd0, 2, StatNone, 32'd0, 32'd0);
			end
			SidRoutine: reject(SidRoutine, NrcSubFunction);
			default: reject(sid, NrcNotSupported);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) crc_lut[i] = lut_entry(i[7:0]);
			max_blob = 32'd16777216;
			timeout_lim = 16'd30;
			block_len = 16'd4096;
			clear_transfer();
			load_addr = '0; sid = '0; msg_idx = '0; fmt = '0; seq_byte = '0;
			addr_acc = '0; size_acc = '0;
			expected_resp.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgMaxBlob: max_blob = cfg_data;
					CfgTimeout: timeout_lim = cfg_data[15:0];
					CfgBlockLen: block_len = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_resp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response byte %h", out_data.resp_byte);
				end else begin
					e = expected_resp.pop_front();
					if (e !== out_data) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %h %b %0d %h %h got %h %b %0d %h %h",
								e.resp_byte, e.resp_last, e.blob_status,
								e.blob_address, e.blob_length, out_data.resp_byte,
								out_data.resp_last, out_data.blob_status,
								out_data.blob_address, out_data.blob_length);
					end
				end
			end
			if (in_valid && in_ready) predict_item(in_data);
		end
	end
endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import udsbd_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = CfgMaxBlob;
	logic [31:0] cfg_data = '0;
	int fail_count, pending_count;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit hold_go = 0;
	bit hold_done = 0;
	bit stall_mode = 0;
	bit no_gaps = 0;
	int sent_items = 0;

	udsbd_in_if in_ch();
	udsbd_out_if out_ch();

	uds_block_download_receiver dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	udsbd_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_data(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_data(out_ch.data), .fail_count(fail_count),
		.pending_count(pending_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done <= 1;
			hold_cycles <= 200;
			out_ch.ready <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 0;
		end else if (stall_mode)
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		else
			out_ch.ready <= 1;
	end

	always @(posedge clk) if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;

	task automatic send(input logic tick, input logic [7:0] b, input logic last);
		if (!no_gaps && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= '{req_type: tick, data_byte: b, msg_last: last};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_msg(input logic [7:0] m [$]);
		foreach (m[i]) send(1'b0, m[i], i == m.size() - 1);
	endtask

	task automatic settle();
		in_ch.valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] v);
		settle();
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic download(input logic [31:0] addr, input logic [31:0] size);
		send_msg('{SidDownload, 8'h00, 8'h44, addr[31:24], addr[23:16], addr[15:8],
			addr[7:0], size[31:24], size[23:16], size[15:8], size[7:0]});
	endtask

	task automatic blob_run(input bit good_crc);
		logic [7:0] payload [$];
		logic [7:0] blk [$];
		logic [31:0] c;
		int n, pos, seq, k;
		n = $urandom_range(0, 14);
		c = CrcOnes;
		for (int i = 0; i < n; i++) begin
			payload.push_back(8'($urandom));
			c = (c >> 8) ^ crc_entry(c[7:0] ^ payload[i]);
		end
		c = c ^ CrcOnes;
		if (!good_crc) c[5'($urandom_range(0, 31))] ^= 1'b1;
		if ($urandom_range(0, 5) != 0)
			for (int j = 0; j < 4; j++) payload.push_back(c[8*j +: 8]);
		download($urandom, 32'(payload.size() + $urandom_range(0, 3) + 1));
		pos = 0; seq = 1;
		while (pos < payload.size()) begin
			k = $urandom_range(1, 6);
			blk = '{SidTransfer, seq[7:0]};
			for (int j = 0; j < k && pos + j < payload.size(); j++)
				blk.push_back(payload[pos + j]);
			if ($urandom_range(0, 9) == 0) begin
				blk[1] = blk[1] + 8'd1;
				send_msg(blk);
			end else if ($urandom_range(0, 15) == 0) begin
				send(1'b1, 8'($urandom), 1'($urandom));
			end else begin
				send_msg(blk);
				pos += blk.size() - 2;
				seq++;
			end
		end
		send_msg('{SidExit});
	endtask

	initial begin
		logic [7:0] m [$];
		in_ch.valid <= 0;
		in_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_msg('{SidTester, 8'h00});
		send_msg('{SidTester, 8'h80});
		send_msg('{SidTester});
		send_msg('{SidRoutine, 8'h01, 8'hFF});
		send_msg('{8'hFF});
		send_msg('{SidTransfer, 8'h01, 8'hAA});
		send_msg('{SidExit});
		send_msg('{SidDownload, 8'h00});
		send_msg('{SidDownload, 8'h00, 8'h05, 8'h00});
		send_msg('{SidDownload, 8'h00, 8'h11, 8'h00});
		send_msg('{SidDownload, 8'h00, 8'h11, 8'h00, 8'h00});
		send(1'b1, 8'h00, 1'b1);
		download(32'hFFFF_FFFF, 32'd8);
		download(32'h0, 32'd8);
		send_msg('{SidTransfer});
		send_msg('{SidTransfer, 8'h02, 8'h00});
		send_msg('{SidTransfer, 8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
			8'h07, 8'h08, 8'h09});
		send_msg('{SidTransfer, 8'h01, 8'h01, 8'h02});
		send_msg('{SidExit});
		write_cfg(CfgMaxBlob, 32'hFFFF_FFFF);
		write_cfg(CfgBlockLen, 32'h0000_FFFF);
		write_cfg(CfgTimeout, 32'd0);
		download(32'h1234_5678, 32'hFFFF_FFFF);
		send(1'b1, 8'h00, 1'b0);
		send_msg('{SidExit});
		write_cfg(CfgMaxBlob, 32'd1);
		write_cfg(CfgBlockLen, 32'd0);
		write_cfg(CfgTimeout, 32'd3);
		download(32'h5, 32'd2);
		download(32'h5, 32'd1);
		repeat (5) send(1'b1, 8'hFF, 1'b1);
		write_cfg(CfgMaxBlob, 32'd64);
		write_cfg(CfgTimeout, 32'd65535);
		write_cfg(CfgBlockLen, 32'h0000_0800);
		hold_go = 1;
		no_gaps = 1;
		for (int i = 0; i < 6; i++) send_msg('{SidTester, 8'h01});
		no_gaps = 0;
		settle();
		while (sent_items < 400) begin
			if ($urandom_range(0, 9) < 7) blob_run($urandom_range(0, 2) != 0);
			else begin
				m = {};
				repeat ($urandom_range(1, 6)) m.push_back(8'($urandom));
				if ($urandom_range(0, 1)) m[0] = 8'($urandom_range(8'h31, 8'h3E));
				send_msg(m);
				if ($urandom_range(0, 3) == 0) send(1'b1, 8'($urandom), 1'($urandom));
			end
			if ($urandom_range(0, 19) == 0) write_cfg(CfgTimeout, $urandom_range(0, 40));
		end
		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
